// File: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers. Define NO_ASSERTIONS to drop them.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define BCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define BCA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BCA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/bca_pkg.sv
// ============================================================================
// bca_pkg
// Types, constants and helpers of the block chain allocator.
// ============================================================================
package bca_pkg;

    localparam int BLOCK_COUNT = 512;
    localparam int FIELD_W     = 10;
    localparam int STEP_W      = 9;
    localparam int KIND_W      = 2;
    localparam int STAT_W      = 2;
    localparam int IDX_W       = $clog2(BLOCK_COUNT);

    localparam int MAP_WORD_W  = 32;
    localparam int MAP_BIT_W   = $clog2(MAP_WORD_W);
    localparam int MAP_WORDS   = (BLOCK_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int MAP_ADDR_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam logic [FIELD_W-1:0] END_MARK   = '1;
    localparam logic [FIELD_W-1:0] POOL_LIMIT = FIELD_W'(BLOCK_COUNT);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WALK  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EARLY   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_WR,
        S_A_LINK,
        S_F_RD,
        S_F_WR,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] block;
        logic [STEP_W-1:0]  steps;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIELD_W-1:0] result_block;
        logic [FIELD_W-1:0] freed_count;
        logic [FIELD_W-1:0] used_blocks;
    } t_out_item;

    typedef struct packed {
        logic                  rd_en;
        logic [MAP_ADDR_W-1:0] rd_word;
        logic [MAP_ADDR_W-1:0] pr_word;
        logic                  wr_en;
        logic [MAP_ADDR_W-1:0] wr_word;
        logic [MAP_WORD_W-1:0] wr_data;
    } t_map_req;

    typedef struct packed {
        logic [MAP_WORD_W-1:0] rd_data;
        logic [MAP_WORD_W-1:0] pr_data;
        logic [MAP_BIT_W-1:0]  free_bit;
        logic [MAP_ADDR_W-1:0] free_word;
        logic                  any_free;
    } t_map_rsp;

    // Bits of a bitmap word that map onto blocks of the pool.
    function automatic logic [MAP_WORD_W-1:0] word_mask(input logic [MAP_ADDR_W-1:0] w);
        logic [MAP_WORD_W-1:0] m;
        for (int b = 0; b < MAP_WORD_W; b++) begin
            m[b] = ((int'(w) * MAP_WORD_W + b) < BLOCK_COUNT);
        end
        return m;
    endfunction

    function automatic logic [MAP_ADDR_W-1:0] word_of(input logic [FIELD_W-1:0] blk);
        return MAP_ADDR_W'(blk >> MAP_BIT_W);
    endfunction

    function automatic logic [MAP_BIT_W-1:0] bit_of(input logic [FIELD_W-1:0] blk);
        return blk[MAP_BIT_W-1:0];
    endfunction

endpackage

// File: rtl/bca_map.sv
// ============================================================================
// bca_map
// Allocation bitmap: word memory, per-word full summary, lowest free search.
// ============================================================================
`include "assert_macros.svh"

module bca_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bca_pkg::t_map_req i_req,
    output bca_pkg::t_map_rsp o_rsp
);
    import bca_pkg::*;

    logic [MAP_WORD_W-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_W-1:0] r_rd_data;
    logic [MAP_WORD_W-1:0] r_pr_data;
    logic [MAP_ADDR_W-1:0] r_rd_word;
    logic [MAP_WORDS-1:0]  r_full;
    logic [MAP_WORDS-1:0]  n_full;
    logic [MAP_WORD_W-1:0] taken;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            map_mem[i_req.wr_word] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= map_mem[i_req.rd_word];
            r_pr_data <= map_mem[i_req.pr_word];
            r_rd_word <= i_req.rd_word;
        end
    end

    always_comb begin
        n_full = r_full;
        if (i_req.wr_en) begin
            n_full[i_req.wr_word] = &(i_req.wr_data | ~word_mask(i_req.wr_word));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else begin
            r_full <= n_full;
        end
    end

    assign taken = r_rd_data | ~word_mask(r_rd_word);

    always_comb begin
        o_rsp.rd_data   = r_rd_data;
        o_rsp.pr_data   = r_pr_data;
        o_rsp.free_word = '0;
        o_rsp.any_free  = 1'b0;
        o_rsp.free_bit  = '0;
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                o_rsp.free_word = MAP_ADDR_W'(w);
                o_rsp.any_free  = 1'b1;
            end
        end
        for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
            if (!taken[b]) begin
                o_rsp.free_bit = MAP_BIT_W'(b);
            end
        end
    end

    `BCA_NEVER(a_map_rw_overlap, i_clk, i_rst_n, i_req.rd_en && i_req.wr_en, "bitmap read and write in one cycle")
    `BCA_ASSERT(a_map_wr_range, i_clk, i_rst_n, i_req.wr_en |-> (int'(i_req.wr_word) < MAP_WORDS), "bitmap write beyond pool")

endmodule

// File: rtl/block_chain_allocator.sv
// ============================================================================
// block_chain_allocator
// FAT-style block chain manager: bitmap allocation, chain free, link walk.
// ============================================================================
//  channel   direction  handshake                payload
//  request   in         i_in_valid / o_in_stall  i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
//  Allocate: bitmap read, then bitmap write (RMW) and new link write, then the
//  predecessor link write when that block is in use. Free: per chain block
//  visited, a link/bitmap read, then a write. Walk: one link memory read per link.
//  After reset a clearing pass over the link table and bitmap runs with o_in_stall high.
//  A finished result waits while the output register is held by i_out_stall;
//  the next request is taken in the cycle the result enters that register.
// ============================================================================
`include "assert_macros.svh"

module block_chain_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bca_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output bca_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import bca_pkg::*;

    logic [FIELD_W-1:0] link_mem [BLOCK_COUNT];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic [FIELD_W-1:0] r_cur, n_cur;
    logic [FIELD_W-1:0] r_pred, n_pred;
    logic [FIELD_W-1:0] r_new, n_new;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [FIELD_W-1:0] r_freed, n_freed;
    logic [FIELD_W-1:0] r_used, n_used;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic [FIELD_W-1:0] r_res_block, n_res_block;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_data, n_out_data;
    logic [FIELD_W-1:0] r_link_rd;

    logic               link_rd_en;
    logic [IDX_W-1:0]   link_rd_addr;
    logic               link_wr_en;
    logic [IDX_W-1:0]   link_wr_addr;
    logic [FIELD_W-1:0] link_wr_data;

    t_map_req           map_req;
    t_map_rsp           map_rsp;

    logic               slot_free;
    logic               can_start;
    logic               accept;
    logic [FIELD_W-1:0] alloc_blk;
    logic               pred_ok;
    logic               was_set;

    bca_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_rsp   (map_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (link_wr_en) begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_rd_en) begin
            r_link_rd <= link_mem[link_rd_addr];
        end
    end

    assign slot_free = !r_out_valid || !i_out_stall;
    assign can_start = (r_state == S_IDLE) || ((r_state == S_DONE) && slot_free);
    assign accept    = i_in_valid && can_start;
    assign alloc_blk = r_cur | FIELD_W'(map_rsp.free_bit);
    assign pred_ok   = (r_pred < POOL_LIMIT) && map_rsp.pr_data[bit_of(r_pred)];
    assign was_set   = map_rsp.rd_data[bit_of(r_cur)];

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_pred       = r_pred;
        n_new        = r_new;
        n_cnt        = r_cnt;
        n_freed      = r_freed;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        link_rd_en   = 1'b0;
        link_rd_addr = '0;
        link_wr_en   = 1'b0;
        link_wr_addr = '0;
        link_wr_data = END_MARK;
        map_req      = '0;

        case (r_state)
            S_CLEAR: begin
                link_wr_en   = 1'b1;
                link_wr_addr = r_clr;
                if (int'(r_clr) < MAP_WORDS) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_word = MAP_ADDR_W'(r_clr);
                    map_req.wr_data = '0;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == IDX_W'(BLOCK_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_A_WR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_word = word_of(alloc_blk);
                map_req.wr_data = map_rsp.rd_data | (MAP_WORD_W'(1) << map_rsp.free_bit);
                link_wr_en      = 1'b1;
                link_wr_addr    = IDX_W'(alloc_blk);
                n_used          = r_used + 1'b1;
                n_res_status    = STAT_OK;
                n_res_block     = alloc_blk;
                n_new           = alloc_blk;
                n_state         = pred_ok ? S_A_LINK : S_DONE;
            end
            S_A_LINK: begin
                link_wr_en   = 1'b1;
                link_wr_addr = IDX_W'(r_pred);
                link_wr_data = r_new;
                n_state      = S_DONE;
            end
            S_F_RD: begin
                link_rd_en      = 1'b1;
                link_rd_addr    = IDX_W'(r_cur);
                map_req.rd_en   = 1'b1;
                map_req.rd_word = word_of(r_cur);
                map_req.pr_word = word_of(r_cur);
                n_state         = S_F_WR;
            end
            S_F_WR: begin
                link_wr_en   = 1'b1;
                link_wr_addr = IDX_W'(r_cur);
                if (was_set) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_word = word_of(r_cur);
                    map_req.wr_data = map_rsp.rd_data
                                      & ~(MAP_WORD_W'(1) << bit_of(r_cur));
                    n_freed         = r_freed + 1'b1;
                    n_used          = r_used - FIELD_W'(r_used != '0);
                end
                n_cur = r_link_rd;
                if (r_link_rd < POOL_LIMIT) begin
                    n_state = S_F_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_res_block = (r_link_rd < POOL_LIMIT) ? r_link_rd : END_MARK;
                    n_state     = S_DONE;
                end else if (r_link_rd >= POOL_LIMIT) begin
                    n_res_status = STAT_EARLY;
                    n_state      = S_DONE;
                end else begin
                    link_rd_en   = 1'b1;
                    link_rd_addr = IDX_W'(r_link_rd);
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data.status       = r_res_status;
                    n_out_data.result_block = r_res_block;
                    n_out_data.freed_count  = r_freed;
                    n_out_data.used_blocks  = r_used;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            n_freed      = '0;
            n_res_status = STAT_OK;
            n_res_block  = END_MARK;
            n_state      = S_DONE;
            case (i_in_data.kind)
                KIND_ALLOC: begin
                    if (!map_rsp.any_free) begin
                        n_res_status = STAT_NOSPACE;
                    end else begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_word = map_rsp.free_word;
                        map_req.pr_word = word_of(i_in_data.block);
                        n_cur           = FIELD_W'(map_rsp.free_word) << MAP_BIT_W;
                        n_pred          = i_in_data.block;
                        n_state         = S_A_WR;
                    end
                end
                KIND_FREE: begin
                    if (i_in_data.block < POOL_LIMIT) begin
                        link_rd_en      = 1'b1;
                        link_rd_addr    = IDX_W'(i_in_data.block);
                        map_req.rd_en   = 1'b1;
                        map_req.rd_word = word_of(i_in_data.block);
                        map_req.pr_word = word_of(i_in_data.block);
                        n_cur           = i_in_data.block;
                        n_state         = S_F_WR;
                    end
                end
                KIND_WALK: begin
                    if (i_in_data.steps == '0) begin
                        n_res_block = (i_in_data.block < POOL_LIMIT) ? i_in_data.block
                                                                     : END_MARK;
                    end else if (i_in_data.block >= POOL_LIMIT) begin
                        n_res_status = STAT_EARLY;
                    end else begin
                        link_rd_en   = 1'b1;
                        link_rd_addr = IDX_W'(i_in_data.block);
                        n_cnt        = i_in_data.steps - 1'b1;
                        n_state      = S_WALK;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_pred       <= n_pred;
        r_new        <= n_new;
        r_cnt        <= n_cnt;
        r_freed      <= n_freed;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_out_data   <= n_out_data;
    end

    assign o_in_stall  = !can_start;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `BCA_ASSERT(a_clear_stalls, i_clk, i_rst_n, (r_state == S_CLEAR) |-> o_in_stall, "request taken during clearing pass")
    `BCA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= POOL_LIMIT, "used count beyond pool size")
    `BCA_ASSERT(a_nospace_full, i_clk, i_rst_n, (o_out_valid && (o_out_data.status == STAT_NOSPACE)) |-> (o_out_data.used_blocks == POOL_LIMIT), "no-space result with free blocks left")

endmodule

// File: sim/tb_block_chain_allocator.sv
// ============================================================================
// tb_block_chain_allocator
// Self-checking testbench of the block chain allocator. Requests are driven
// through the valid/stall channel and every accepted transaction is run
// through a local model of the bitmap, the link table and the used count.
// Each result is compared field by field with the oldest expected one.
// Directed cases, a full pool, a long result hold-off and random chain
// traffic are run in turn, most with random idle bursts on both channels.
// ============================================================================
module tb_block_chain_allocator;
    import bca_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    t_in_item  req_data  = '0;
    logic      req_stall;
    logic      rsp_valid;
    t_out_item rsp_data;
    logic      rsp_stall = 1'b0;

    bit        req_gaps   = 1'b0;
    bit        rsp_gaps   = 1'b0;
    int        hold_len   = 0;
    int        mismatches = 0;
    int        chain_heads[$];
    t_out_item expected_rsp[$];

    bit                 blk_used [BLOCK_COUNT];
    logic [FIELD_W-1:0] blk_link [BLOCK_COUNT];
    logic [FIELD_W-1:0] used_total;

    block_chain_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_data   (req_data),
        .o_in_stall  (req_stall),
        .o_out_valid (rsp_valid),
        .o_out_data  (rsp_data),
        .i_out_stall (rsp_stall)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Applies one request to the local copy of the allocator state.
    function automatic t_out_item chain_apply(input t_in_item it);
        t_out_item   r;
        int unsigned cur;
        int unsigned nxt;
        int unsigned n;
        bit          pred_ok;
        bit          found;
        r.status       = STAT_OK;
        r.result_block = END_MARK;
        r.freed_count  = '0;
        case (it.kind)
            KIND_ALLOC: begin
                pred_ok = (it.block < BLOCK_COUNT) && blk_used[it.block];
                found   = 1'b0;
                r.status = STAT_NOSPACE;
                for (n = 0; n < BLOCK_COUNT && !found; n++) begin
                    if (!blk_used[n]) begin
                        found          = 1'b1;
                        blk_used[n]    = 1'b1;
                        blk_link[n]    = END_MARK;
                        used_total     = used_total + 1'b1;
                        if (pred_ok)
                            blk_link[it.block] = FIELD_W'(n);
                        r.status       = STAT_OK;
                        r.result_block = FIELD_W'(n);
                    end
                end
            end
            KIND_FREE: begin
                cur = 32'(it.block);
                n   = 0;
                for (int g = 0; g <= BLOCK_COUNT && cur < BLOCK_COUNT; g++) begin
                    nxt = 32'(blk_link[cur]);
                    if (blk_used[cur]) begin
                        blk_used[cur] = 1'b0;
                        n++;
                        if (used_total != 0)
                            used_total = used_total - 1'b1;
                    end
                    blk_link[cur] = END_MARK;
                    cur = nxt;
                end
                r.freed_count = FIELD_W'(n);
            end
            KIND_WALK: begin
                cur = 32'(it.block);
                for (n = 0; n < it.steps && r.status == STAT_OK; n++) begin
                    if (cur >= BLOCK_COUNT)
                        r.status = STAT_EARLY;
                    else
                        cur = 32'(blk_link[cur]);
                end
                if (r.status == STAT_OK && cur < BLOCK_COUNT)
                    r.result_block = FIELD_W'(cur);
            end
            default: ;
        endcase
        r.used_blocks = used_total;
        return r;
    endfunction

    // Last block of a chain and the number of links up to it.
    function automatic int chain_end(input int head, output int len);
        int cur;
        cur = head;
        len = 0;
        while (blk_link[cur] < BLOCK_COUNT && len < BLOCK_COUNT) begin
            cur = int'(blk_link[cur]);
            len++;
        end
        return cur;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got %0d expected %0d",
                 mismatches, $realtime, what, got, want);
    endtask

    task automatic send_request(input logic [KIND_W-1:0] k, input int blk, input int stp,
                                output t_out_item predicted);
        t_in_item it;
        it.kind  = k;
        it.block = FIELD_W'(blk);
        it.steps = STEP_W'(stp);
        if (req_gaps && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        do @(posedge clk); while (req_stall);
        predicted = chain_apply(it);
        expected_rsp.push_back(predicted);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result checker: one transaction per edge with valid high and stall low.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("result with nothing pending, block",
                                rsp_data.result_block, -1);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_data.status !== want.status)
                    report_mismatch("status", rsp_data.status, want.status);
                if (rsp_data.result_block !== want.result_block)
                    report_mismatch("result_block", rsp_data.result_block,
                                    want.result_block);
                if (rsp_data.freed_count !== want.freed_count)
                    report_mismatch("freed_count", rsp_data.freed_count,
                                    want.freed_count);
                if (rsp_data.used_blocks !== want.used_blocks)
                    report_mismatch("used_blocks", rsp_data.used_blocks,
                                    want.used_blocks);
            end
        end
    end

    // Result side stall: random bursts, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                rsp_stall <= 1'b0;
            end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    task automatic test_directed_cases();
        t_out_item p;
        send_request(KIND_WALK, 0, 0, p);
        send_request(KIND_WALK, END_MARK, 0, p);
        send_request(KIND_WALK, 700, 1, p);
        send_request(KIND_WALK, 5, 1, p);
        send_request(KIND_WALK, 511, 511, p);
        send_request(KIND_ALLOC, END_MARK, 0, p);
        send_request(KIND_ALLOC, 0, 0, p);
        send_request(KIND_ALLOC, 1, 0, p);
        // free and out-of-range predecessors are ignored
        send_request(KIND_ALLOC, 100, 0, p);
        send_request(KIND_ALLOC, 512, 0, p);
        send_request(KIND_ALLOC, 3, 0, p);
        send_request(KIND_ALLOC, 3, 0, p);
        send_request(KIND_WALK, 0, 2, p);
        send_request(KIND_WALK, 0, 3, p);
        send_request(KIND_WALK, 0, 4, p);
        send_request(KIND_UNUSED, 0, 511, p);
        send_request(KIND_UNUSED, END_MARK, 0, p);
        send_request(KIND_FREE, END_MARK, 0, p);
        send_request(KIND_FREE, 600, 0, p);
        send_request(KIND_FREE, 1, 0, p);
        // block 0 still links to the freed block 1
        send_request(KIND_WALK, 0, 2, p);
        send_request(KIND_FREE, 0, 0, p);
        send_request(KIND_FREE, 3, 511, p);
    endtask

    task automatic test_pool_full();
        t_out_item p;
        int        head;
        int        tail;
        for (int b = 0; b < BLOCK_COUNT; b++)
            if (blk_used[b])
                send_request(KIND_FREE, b, 0, p);
        head = -1;
        tail = int'(END_MARK);
        while (used_total < BLOCK_COUNT) begin
            send_request(KIND_ALLOC, tail, 0, p);
            if (head < 0)
                head = int'(p.result_block);
            tail = int'(p.result_block);
        end
        send_request(KIND_ALLOC, tail, 0, p);
        send_request(KIND_ALLOC, END_MARK, 0, p);
        send_request(KIND_WALK, head, 511, p);
        send_request(KIND_WALK, head, 510, p);
        send_request(KIND_FREE, head, 0, p);
    endtask

    task automatic test_back_pressure();
        t_out_item p;
        req_gaps = 1'b0;
        rsp_gaps = 1'b0;
        hold_len = HOLD_CYCLES;
        repeat (40) begin
            if ($urandom_range(0, 1) == 0)
                send_request(KIND_ALLOC, $urandom_range(0, 1023), 0, p);
            else
                send_request(KIND_WALK, $urandom_range(0, 1023), $urandom_range(0, 3), p);
        end
        drain();
    endtask

    task automatic test_random(input int count, input bit gaps);
        t_out_item p;
        int        pick;
        int        idx;
        int        head;
        int        tail;
        int        len;
        req_gaps = gaps;
        rsp_gaps = gaps;
        repeat (count) begin
            for (int i = chain_heads.size() - 1; i >= 0; i--)
                if (!blk_used[chain_heads[i]])
                    chain_heads.delete(i);
            pick = $urandom_range(0, 99);
            if (used_total > 440 && pick < 45)
                pick = 70;
            if (chain_heads.size() == 0 && pick >= 10 && pick < 80)
                pick = 0;
            head = 0;
            len  = 0;
            tail = 0;
            if (chain_heads.size() != 0) begin
                idx  = $urandom_range(0, chain_heads.size() - 1);
                head = chain_heads[idx];
                tail = chain_end(head, len);
            end
            if (pick < 10) begin
                case ($urandom_range(0, 2))
                    0: send_request(KIND_ALLOC, END_MARK, 0, p);
                    1: send_request(KIND_ALLOC, $urandom_range(BLOCK_COUNT, 1023), 0, p);
                    default: send_request(KIND_ALLOC, $urandom_range(0, BLOCK_COUNT - 1),
                                          $urandom_range(0, 511), p);
                endcase
                if (p.status == STAT_OK)
                    chain_heads.push_back(int'(p.result_block));
            end else if (pick < 45) begin
                send_request(KIND_ALLOC, tail, 0, p);
            end else if (pick < 65) begin
                if ($urandom_range(0, 4) != 0)
                    send_request(KIND_WALK, head, $urandom_range(0, len + 1), p);
                else
                    send_request(KIND_WALK, head, $urandom_range(0, 511), p);
            end else if (pick < 80) begin
                send_request(KIND_FREE, head, $urandom_range(0, 511), p);
            end else if (pick < 88) begin
                send_request(KIND_FREE, $urandom_range(0, BLOCK_COUNT - 1), 0, p);
            end else begin
                send_request(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 1023),
                             $urandom_range(0, 511), p);
            end
        end
    endtask

    initial begin
        for (int b = 0; b < BLOCK_COUNT; b++) begin
            blk_used[b] = 1'b0;
            blk_link[b] = END_MARK;
        end
        used_total = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        req_gaps = 1'b1;
        rsp_gaps = 1'b1;
        test_directed_cases();
        drain();
        test_pool_full();
        drain();
        test_back_pressure();
        test_random(180, 1'b1);
        test_random(90, 1'b0);
        drain();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bca_pkg.sv
rtl/bca_map.sv
rtl/block_chain_allocator.sv
sim/tb_block_chain_allocator.sv
